// ----- sv/kvbt_pkg.sv -----
// Shared types, constants and keyword tables for the key/value block tokenizer.
package kvbt_pkg;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       end_of_text;
	} text_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic [2:0] field_kind;
		logic [3:0] type_code;
		logic [7:0] value_byte;
		logic [1:0] error_kind;
	} result_t;

	typedef enum logic [2:0] {
		PH_OUTSIDE    = 3'd0,
		PH_NAME_WAIT  = 3'd1,
		PH_NAME_IN    = 3'd2,
		PH_NAME_DONE  = 3'd3,
		PH_VALUE_WAIT = 3'd4,
		PH_VALUE_IN   = 3'd5,
		PH_AFTER      = 3'd6,
		PH_ERROR      = 3'd7
	} phase_t;

	localparam int NAME_NUM = 7;
	localparam int TYPE_NUM = 9;

	typedef struct packed {
		phase_t              phase;
		logic [NAME_NUM-1:0] name_cand;
		logic [TYPE_NUM-1:0] type_cand;
		logic [4:0]          mlen;
		logic [2:0]          cur_field;
	} state_t;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_OPEN      = 3'd1;
	localparam logic [2:0] EV_VALUE     = 3'd2;
	localparam logic [2:0] EV_FIELD_END = 3'd3;
	localparam logic [2:0] EV_CLOSE     = 3'd4;
	localparam logic [2:0] EV_ERROR     = 3'd5;
	localparam logic [2:0] EV_END_OK    = 3'd6;
	localparam logic [2:0] EV_END_FAULT = 3'd7;

	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_NAME = 2'd1;
	localparam logic [1:0] ERR_TYPE = 2'd2;
	localparam logic [1:0] ERR_CHAR = 2'd3;

	localparam logic [2:0] FLD_TYPE = 3'd0;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam logic [4:0] LEN_MAX = 5'd31;

	localparam logic [47:0] NAME_WORDS [NAME_NUM] = '{
		48'("type"), 48'("part"), 48'("data"), 48'("option"),
		48'("id"), 48'("target"), 48'("file")
	};
	localparam logic [4:0] NAME_LEN [NAME_NUM] = '{
		5'd4, 5'd4, 5'd4, 5'd6, 5'd2, 5'd6, 5'd4
	};

	localparam logic [127:0] TYPE_WORDS [TYPE_NUM] = '{
		128'("access"), 128'("access,operation"), 128'("color"), 128'("drag"),
		128'("image"), 128'("info"), 128'("script"), 128'("signal"), 128'("text")
	};
	localparam logic [4:0] TYPE_WLEN [TYPE_NUM] = '{
		5'd6, 5'd16, 5'd5, 5'd4, 5'd5, 5'd4, 5'd6, 5'd6, 5'd4
	};

	localparam state_t STATE_RESET = '{
		phase:     PH_OUTSIDE,
		name_cand: '1,
		type_cand: '1,
		mlen:      '0,
		cur_field: '0
	};

	function automatic logic [7:0] name_ch(input logic [2:0] i, input logic [4:0] pos);
		logic [4:0] k;
		k = NAME_LEN[i] - 5'd1 - pos;
		return NAME_WORDS[i][{k[2:0], 3'b000} +: 8];
	endfunction

	function automatic logic [7:0] type_ch(input logic [3:0] i, input logic [4:0] pos);
		logic [4:0] k;
		k = TYPE_WLEN[i] - 5'd1 - pos;
		return TYPE_WORDS[i][{k[3:0], 3'b000} +: 8];
	endfunction

	function automatic logic [4:0] len_inc(input logic [4:0] len);
		return (len == LEN_MAX) ? len : len + 5'd1;
	endfunction

endpackage

// ----- sv/kvbt_step.sv -----
// Next-state and result logic for one character of the tokenizer.
module kvbt_step (
	input  kvbt_pkg::state_t  st,
	input  kvbt_pkg::text_t   item,
	output kvbt_pkg::state_t  nxt,
	output kvbt_pkg::result_t res
);
	import kvbt_pkg::*;

	logic [7:0]          c;
	logic                eot;
	logic                is_sp;
	logic                is_end;
	logic                fresh_name;
	logic [NAME_NUM-1:0] nm_base;
	logic [4:0]          nm_pos;
	logic [NAME_NUM-1:0] nm_keep;
	logic [TYPE_NUM-1:0] ty_keep;
	logic                nm_hit;
	logic [2:0]          nm_idx;
	logic                ty_hit;
	logic [3:0]          ty_idx;

	assign c      = item.text_byte;
	assign eot    = item.end_of_text || (c == CH_NUL);
	assign is_sp  = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
		(c == CH_FF) || (c == CH_CR);
	assign is_end = (c == CH_LF) || (c == CH_CR) || (c == CH_FF);

	assign fresh_name = (st.phase == PH_NAME_WAIT) || (st.phase == PH_AFTER);
	assign nm_base    = fresh_name ? '1 : st.name_cand;
	assign nm_pos     = fresh_name ? 5'd0 : st.mlen;

	always_comb begin
		for (int i = 0; i < NAME_NUM; i++) begin
			nm_keep[i] = nm_base[i] && (nm_pos < NAME_LEN[3'(i)]) &&
				(name_ch(3'(i), nm_pos) == c);
		end
		for (int i = 0; i < TYPE_NUM; i++) begin
			ty_keep[i] = st.type_cand[i] && (st.mlen < TYPE_WLEN[4'(i)]) &&
				(type_ch(4'(i), st.mlen) == c);
		end
	end

	always_comb begin
		nm_hit = 1'b0;
		nm_idx = '0;
		for (int i = NAME_NUM - 1; i >= 0; i--) begin
			if (st.name_cand[i] && (NAME_LEN[3'(i)] == st.mlen)) begin
				nm_hit = 1'b1;
				nm_idx = 3'(i);
			end
		end
		ty_hit = 1'b0;
		ty_idx = '0;
		for (int i = TYPE_NUM - 1; i >= 0; i--) begin
			if (st.type_cand[i] && (TYPE_WLEN[4'(i)] == st.mlen)) begin
				ty_hit = 1'b1;
				ty_idx = 4'(i);
			end
		end
	end

	always_comb begin
		nxt = st;
		res = '0;
		if (eot) begin
			nxt = STATE_RESET;
			if (st.phase == PH_OUTSIDE) begin
				res.event_res = EV_END_OK;
			end else if (st.phase == PH_ERROR) begin
				res.event_res  = EV_END_FAULT;
				res.error_kind = st.cur_field[1:0];
			end else begin
				res.event_res  = EV_END_FAULT;
				res.error_kind = ERR_CHAR;
			end
		end else begin
			unique case (st.phase)
				PH_OUTSIDE: begin
					if (c == CH_LBRACE) begin
						nxt.phase     = PH_NAME_WAIT;
						res.event_res = EV_OPEN;
					end
				end
				PH_NAME_WAIT, PH_NAME_IN, PH_AFTER: begin
					if (is_sp) begin
						if (st.phase == PH_NAME_IN) begin
							nxt.phase = PH_NAME_DONE;
						end
					end else if (st.phase == PH_AFTER && c == CH_RBRACE) begin
						nxt.phase     = PH_OUTSIDE;
						res.event_res = EV_CLOSE;
					end else if (st.phase == PH_NAME_IN && c == CH_EQ) begin
						if (!nm_hit) begin
							nxt.phase      = PH_ERROR;
							nxt.cur_field  = {1'b0, ERR_NAME};
							res.event_res  = EV_ERROR;
							res.error_kind = ERR_NAME;
						end else begin
							nxt.cur_field = nm_idx;
							nxt.phase     = (nm_idx == FLD_TYPE) ? PH_VALUE_WAIT : PH_VALUE_IN;
							nxt.type_cand = '1;
							nxt.mlen      = '0;
						end
					end else if (fresh_name && (c == CH_EQ || c == CH_RBRACE)) begin
						nxt.phase      = PH_ERROR;
						nxt.cur_field  = {1'b0, ERR_CHAR};
						res.event_res  = EV_ERROR;
						res.error_kind = ERR_CHAR;
					end else begin
						nxt.name_cand = nm_keep;
						if (nm_keep == '0) begin
							nxt.mlen       = nm_pos;
							nxt.phase      = PH_ERROR;
							nxt.cur_field  = {1'b0, ERR_NAME};
							res.event_res  = EV_ERROR;
							res.error_kind = ERR_NAME;
						end else begin
							nxt.mlen  = len_inc(nm_pos);
							nxt.phase = PH_NAME_IN;
						end
					end
				end
				PH_NAME_DONE: begin
					if (is_sp) begin
						nxt.phase = PH_NAME_DONE;
					end else if (c == CH_EQ && nm_hit) begin
						nxt.cur_field = nm_idx;
						nxt.phase     = (nm_idx == FLD_TYPE) ? PH_VALUE_WAIT : PH_VALUE_IN;
						nxt.type_cand = '1;
						nxt.mlen      = '0;
					end else begin
						nxt.phase      = PH_ERROR;
						nxt.cur_field  = (c == CH_EQ) ? {1'b0, ERR_NAME} : {1'b0, ERR_CHAR};
						res.event_res  = EV_ERROR;
						res.error_kind = (c == CH_EQ) ? ERR_NAME : ERR_CHAR;
					end
				end
				PH_VALUE_WAIT, PH_VALUE_IN: begin
					if (st.phase == PH_VALUE_WAIT && is_sp) begin
						nxt.phase = PH_VALUE_WAIT;
					end else if (st.phase == PH_VALUE_IN && is_end) begin
						if (st.cur_field == FLD_TYPE && !ty_hit) begin
							nxt.phase      = PH_ERROR;
							nxt.cur_field  = {1'b0, ERR_TYPE};
							res.event_res  = EV_ERROR;
							res.error_kind = ERR_TYPE;
						end else begin
							nxt.phase      = PH_AFTER;
							res.event_res  = EV_FIELD_END;
							res.field_kind = st.cur_field;
							res.type_code  = (st.cur_field == FLD_TYPE) ? ty_idx : 4'd0;
						end
					end else if (st.cur_field == FLD_TYPE) begin
						nxt.type_cand = ty_keep;
						if (ty_keep == '0) begin
							nxt.phase      = PH_ERROR;
							nxt.cur_field  = {1'b0, ERR_TYPE};
							res.event_res  = EV_ERROR;
							res.error_kind = ERR_TYPE;
						end else begin
							nxt.mlen  = len_inc(st.mlen);
							nxt.phase = PH_VALUE_IN;
						end
					end else begin
						res.event_res  = EV_VALUE;
						res.field_kind = st.cur_field;
						res.value_byte = c;
					end
				end
				PH_ERROR: begin
					nxt.phase = PH_ERROR;
				end
				default: begin
					nxt = st;
				end
			endcase
		end
	end

endmodule

// ----- sv/keyvalue_block_tokenizer_top.sv -----
// Top level of the key/value block tokenizer: input stage, parser state and result register.
//
//   channel  direction  handshake                  payload
//   text     in         text_valid / text_ready    text   (text_byte, end_of_text)
//   result   out        result_valid / result_ready result (event, field, type, byte, error)
//
// One character per cycle unless result stalls; results leave through the result register.
// The parser state register is the only loop: one character's update per unstalled cycle.
// Reset clears the input stage, the result register and the parser state.
// A stall on result holds the result, the input stage and the parser state;
// text stays ready while the input stage is empty.
module keyvalue_block_tokenizer_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_ready,
	input  kvbt_pkg::text_t     text,
	output logic                result_valid,
	input  logic                result_ready,
	output kvbt_pkg::result_t   result
);
	import kvbt_pkg::*;

	text_t   item_s1;
	logic    valid_s1;
	state_t  st_q;
	state_t  st_nxt;
	result_t res_nxt;
	result_t res_q;
	logic    res_valid_q;
	logic    advance;

	assign advance    = !res_valid_q || result_ready;
	assign text_ready = !valid_s1 || advance;

	kvbt_step u_step (
		.st   (st_q),
		.item (item_s1),
		.nxt  (st_nxt),
		.res  (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_ready) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_ready && text_valid) begin
			item_s1 <= text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= STATE_RESET;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
			if (valid_s1) begin
				st_q <= st_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_nxt;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(st_q))
		else $error("parser state changed during result stall");

	a_eot_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && (item_s1.end_of_text || item_s1.text_byte == CH_NUL))
		|=> (st_q.phase == PH_OUTSIDE))
		else $error("end of text did not return parser outside a block");

	a_error_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s1 && res_nxt.event_res == EV_ERROR) |=> (st_q.phase == PH_ERROR))
		else $error("error event without error phase");

	a_error_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q.phase == PH_ERROR) |-> (st_q.cur_field != 3'd0))
		else $error("error phase holds no error kind");

endmodule
